/* rtl/wsd_pkg.sv */
// Shared types and constants for the work-stealing deque.
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned CMD_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_STEAL = 2'd2
  } cmd_e;

  typedef struct packed {
    logic exec;
    logic load;
  } wsd_ctrl_t;

endpackage

/* rtl/wsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/wsd_ctrl.sv */
// Controller state machine: sequences command execution and result hand-off.
`timescale 1ns / 1ps

module wsd_ctrl
  import wsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output wsd_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DONE = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ctrl_o.exec = 1'b0;
    ctrl_o.load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.exec = 1'b1;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/wsd_datapath.sv */
// Datapath: head/tail counters, slot RAM and result registers.
`timescale 1ns / 1ps

module wsd_datapath
  import wsd_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wsd_ctrl_t                       ctrl_i,
  input  cmd_e                            cmd_i,
  input  logic [ENTRY_W-1:0]              push_entry_i,
  output logic                            success_o,
  output logic [ENTRY_W-1:0]              taken_entry_o,
  output logic [$clog2(CAPACITY+1)-1:0]   occupancy_o
);

  localparam int unsigned CW = $clog2(2 * CAPACITY);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam logic [CW:0]   CapX    = (CW+1)'(CAPACITY);
  localparam logic [CW:0]   TwoCapX = (CW+1)'(2 * CAPACITY);
  localparam logic [CW-1:0] CntMax  = CW'(2 * CAPACITY - 1);

  function automatic logic [CW-1:0] inc_cnt(input logic [CW-1:0] v);
    return (v == CntMax) ? '0 : CW'(v + 1'b1);
  endfunction

  function automatic logic [CW-1:0] dec_cnt(input logic [CW-1:0] v);
    return (v == '0) ? CntMax : CW'(v - 1'b1);
  endfunction

  function automatic logic [AW-1:0] slot_idx(input logic [CW-1:0] v);
    logic [CW:0] w;
    w = {1'b0, v};
    return (w >= CapX) ? AW'(w - CapX) : AW'(w);
  endfunction

  logic [CW-1:0]      head_q, head_d;
  logic [CW-1:0]      tail_q, tail_d;
  logic [CW:0]        diff;
  logic [CW:0]        fill;
  logic [CW:0]        fill_next;
  logic               full;
  logic               empty;
  logic [CW-1:0]      tail_dec;
  logic               ok;
  logic               rd;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               pend_ok_q;
  logic               pend_rd_q;
  logic [OW-1:0]      pend_occ_q;
  logic               success_q;
  logic [ENTRY_W-1:0] taken_q;
  logic [OW-1:0]      occ_q;

  assign diff     = {1'b0, tail_q} - {1'b0, head_q};
  assign fill     = (tail_q >= head_q) ? diff : (CW+1)'(diff + TwoCapX);
  assign full     = (fill == CapX);
  assign empty    = (fill == '0);
  assign tail_dec = dec_cnt(tail_q);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    ok        = 1'b0;
    rd        = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = slot_idx(tail_q);
    ram_raddr = slot_idx(head_q);
    fill_next = fill;
    case (cmd_i)
      CMD_PUSH: begin
        if (!full) begin
          ok        = 1'b1;
          ram_we    = ctrl_i.exec;
          tail_d    = inc_cnt(tail_q);
          fill_next = (CW+1)'(fill + 1'b1);
        end
      end
      CMD_POP: begin
        if (!empty) begin
          ok        = 1'b1;
          rd        = 1'b1;
          ram_re    = ctrl_i.exec;
          ram_raddr = slot_idx(tail_dec);
          tail_d    = tail_dec;
          fill_next = (CW+1)'(fill - 1'b1);
        end
      end
      CMD_STEAL: begin
        if (!empty) begin
          ok        = 1'b1;
          rd        = 1'b1;
          ram_re    = ctrl_i.exec;
          head_d    = inc_cnt(head_q);
          fill_next = (CW+1)'(fill - 1'b1);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  wsd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(push_entry_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (ctrl_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      pend_ok_q  <= ok;
      pend_rd_q  <= rd;
      pend_occ_q <= OW'(fill_next);
    end
    if (ctrl_i.load) begin
      success_q <= pend_ok_q;
      taken_q   <= pend_rd_q ? ram_rdata : '0;
      occ_q     <= pend_occ_q;
    end
  end

  assign success_o     = success_q;
  assign taken_entry_o = taken_q;
  assign occupancy_o   = occ_q;

endmodule

/* rtl/work_stealing_deque.sv */
// Top level of the bounded work-stealing deque of task handles.
`timescale 1ns / 1ps

// Bounded ring deque of 32-bit task handles with CAPACITY slots held in one
// RAM. Each command transfer on the slave side (push, pop from the tail,
// steal from the head) yields exactly one result transfer on the master side
// carrying a success flag, the handle taken (zero for push or on failure)
// and the occupancy after the command. A command first updates the counters
// and accesses the slot RAM; then the registered RAM read is loaded into the
// output register, and a stalled master side delays that load. A new command
// is taken while the previous result still waits in the output register.
module work_stealing_deque
  import wsd_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // push_entry[31:0]
  input  logic [ENTRY_W-1:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // taken_entry[31:0], occupancy[32 +: $clog2(CAPACITY+1)], zero padding
  output logic [((ENTRY_W + $clog2(CAPACITY+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // success[0]
  output logic m_axis_tuser
);

  localparam int unsigned OW    = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_W = ((ENTRY_W + OW + 7) / 8) * 8;

  wsd_ctrl_t          ctrl;
  logic               success;
  logic [ENTRY_W-1:0] taken_entry;
  logic [OW-1:0]      occupancy;

  wsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ctrl_o     (ctrl)
  );

  wsd_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cmd_i        (cmd_e'(s_axis_tuser)),
    .push_entry_i (s_axis_tdata),
    .success_o    (success),
    .taken_entry_o(taken_entry),
    .occupancy_o  (occupancy)
  );

  assign m_axis_tdata = OUT_W'({occupancy, taken_entry});
  assign m_axis_tuser = success;

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command taken while another is in execution");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, occupancy} <= (OW+1)'(CAPACITY)))
    else $error("occupancy exceeds capacity");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !success) |-> (taken_entry == '0))
    else $error("failed command returned a handle");

  a_load_on_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> !ctrl.exec)
    else $error("result load and command execution in the same cycle");

endmodule
